// ===== sv/optt_pkg.sv =====
// Shared types and codes for the one-shot and periodic timer table.
package optt_pkg;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [3:0] EV_ADDED      = 4'd0;
  localparam logic [3:0] EV_REF_ZERO   = 4'd1;
  localparam logic [3:0] EV_REF_FULL   = 4'd2;
  localparam logic [3:0] EV_DELETED    = 4'd3;
  localparam logic [3:0] EV_DEL_IGNORE = 4'd4;
  localparam logic [3:0] EV_EXPIRED    = 4'd5;
  localparam logic [3:0] EV_LATE       = 4'd6;
  localparam logic [3:0] EV_WAIT       = 4'd7;
  localparam logic [3:0] EV_NO_TIMERS  = 4'd8;

  localparam logic [9:0] US_PER_MS = 10'd1000;

  typedef struct packed {
    logic        periodic;
    logic [55:0] deadline;
    logic [34:0] period;
  } entry_t;

endpackage

// ===== sv/oneshot_periodic_timer_table_core.sv =====
// Timer table core: slot memory, add, delete and tick sequencer.
//
// An input transfer takes place at a rising edge with start high and busy low.
// Each result appears for one cycle with out_strobe high; out_last marks the
// final result of an input item. The receiver cannot stall the block.
// A rejected add, a delete and an unknown operation complete in the accept
// cycle and busy never rises; the first two register a result, the last none.
// An accepted add scans the valid bits one slot per cycle for the lowest free
// slot, and busy stays high until that scan ends.
// A tick streams every slot through a read, check, write-back and minimum
// pipeline on the dual-port slot memory, one slot per cycle, and once the
// pipeline drains emits the wait result, or a no-timers result if none is active.
// Expiry results come out in slot order during that stream.
// Slot deadlines and periods live in a memory with registered read data;
// a valid bit per slot in flip-flops marks which slots are in use.
// Reset clears the valid bits at once, so the table is empty and usable in
// the next cycle; the memory contents need no clearing.
module oneshot_periodic_timer_table_core #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic        in_periodic,
  input  logic [23:0] in_interval_ms,
  input  logic [3:0]  in_slot,
  input  logic [55:0] in_now_us,
  output logic        out_strobe,
  output logic [3:0]  out_event_res,
  output logic [3:0]  out_slot_index,
  output logic [55:0] out_wait_us,
  output logic        out_last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_TIMERS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_TICK = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                  per_r;
  logic [55:0]           now_r;
  logic [34:0]           period_r;
  logic [CNT_W-1:0]      scan_r;
  logic [NUM_TIMERS-1:0] vld_r, vld_nxt;

  optt_pkg::entry_t ent_mem [NUM_TIMERS];
  optt_pkg::entry_t mem_q;
  optt_pkg::entry_t mem_wdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;

  logic             s1_v_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_v_r, s2_act_r, s2_exp_r, s2_per_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [56:0]      s2_sum_r;
  logic [55:0]      s2_dl0_r;
  logic [34:0]      s2_period_r;
  logic             s3_v_r, s3_act_r;
  logic [55:0]      s3_dl_r;
  logic [55:0]      best_r;
  logic             found_r;

  logic        out_strobe_r, out_strobe_nxt;
  logic [3:0]  out_ev_r, out_ev_nxt;
  logic [3:0]  out_idx_r, out_idx_nxt;
  logic [55:0] out_wait_r, out_wait_nxt;
  logic        out_last_r, out_last_nxt;

  logic [IDX_W-1:0] scan_idx;
  logic             scan_end;
  logic             drained;
  logic             del_ok;
  logic [IDX_W-1:0] del_idx;
  logic [56:0]      add_sum;
  logic [55:0]      add_dl;
  logic [55:0]      s2_sat;
  logic             s2_late;
  logic [55:0]      s2_dl;
  logic [56:0]      fin_diff;
  logic [55:0]      fin_wait;

  assign scan_idx = scan_r[IDX_W-1:0];
  assign scan_end = (scan_r == N_CNT);
  assign drained  = scan_end && !s1_v_r && !s2_v_r && !s3_v_r;
  assign del_ok   = (32'(in_slot) < 32'(NUM_TIMERS));
  assign del_idx  = IDX_W'(in_slot);

  assign add_sum  = {1'b0, now_r} + {22'd0, period_r};
  assign add_dl   = add_sum[56] ? {56{1'b1}} : add_sum[55:0];
  assign s2_sat   = s2_sum_r[56] ? {56{1'b1}} : s2_sum_r[55:0];
  assign s2_late  = (s2_sat < now_r);
  assign s2_dl    = s2_late ? now_r : s2_sat;
  assign fin_diff = {1'b0, best_r} - {1'b0, now_r};
  assign fin_wait = fin_diff[56] ? 56'd0 : fin_diff[55:0];

  always_comb begin
    state_nxt      = state_r;
    vld_nxt        = vld_r;
    mem_we         = 1'b0;
    mem_waddr      = s2_idx_r;
    mem_wdata      = '{periodic: s2_per_r, deadline: s2_dl, period: s2_period_r};
    out_strobe_nxt = 1'b0;
    out_ev_nxt     = optt_pkg::EV_ADDED;
    out_idx_nxt    = 4'd0;
    out_wait_nxt   = 56'd0;
    out_last_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_op)
            optt_pkg::OP_ADD: begin
              if (in_periodic && (in_interval_ms == 24'd0)) begin
                out_strobe_nxt = 1'b1;
                out_ev_nxt     = optt_pkg::EV_REF_ZERO;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            optt_pkg::OP_DEL: begin
              out_strobe_nxt = 1'b1;
              out_idx_nxt    = in_slot;
              out_last_nxt   = 1'b1;
              if (!del_ok || !vld_r[del_idx]) begin
                out_ev_nxt = optt_pkg::EV_DEL_IGNORE;
              end else begin
                out_ev_nxt       = optt_pkg::EV_DELETED;
                vld_nxt[del_idx] = 1'b0;
              end
            end
            optt_pkg::OP_TICK: begin
              state_nxt = S_TICK;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          out_strobe_nxt = 1'b1;
          out_ev_nxt     = optt_pkg::EV_REF_FULL;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!vld_r[scan_idx]) begin
          mem_we            = 1'b1;
          mem_waddr         = scan_idx;
          mem_wdata         = '{periodic: per_r, deadline: add_dl, period: period_r};
          vld_nxt[scan_idx] = 1'b1;
          out_strobe_nxt    = 1'b1;
          out_ev_nxt        = optt_pkg::EV_ADDED;
          out_idx_nxt       = 4'(scan_idx);
          out_last_nxt      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_TICK: begin
        if (s2_v_r && s2_act_r && s2_exp_r) begin
          out_strobe_nxt = 1'b1;
          out_idx_nxt    = 4'(s2_idx_r);
          if (s2_per_r) begin
            mem_we     = 1'b1;
            out_ev_nxt = s2_late ? optt_pkg::EV_LATE : optt_pkg::EV_EXPIRED;
          end else begin
            vld_nxt[s2_idx_r] = 1'b0;
            out_ev_nxt        = optt_pkg::EV_EXPIRED;
          end
        end
        if (drained) begin
          out_strobe_nxt = 1'b1;
          out_ev_nxt     = found_r ? optt_pkg::EV_WAIT : optt_pkg::EV_NO_TIMERS;
          out_wait_nxt   = found_r ? fin_wait : 56'd0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= ent_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      s1_v_r       <= (state_r == S_TICK) && !scan_end;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_ev_r   <= out_ev_nxt;
    out_idx_r  <= out_idx_nxt;
    out_wait_r <= out_wait_nxt;
    out_last_r <= out_last_nxt;

    if ((state_r == S_IDLE) && start) begin
      per_r    <= in_periodic;
      now_r    <= in_now_us;
      period_r <= {11'd0, in_interval_ms} * {25'd0, optt_pkg::US_PER_MS};
      scan_r   <= '0;
      found_r  <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (!scan_end && vld_r[scan_idx]) begin
        scan_r <= scan_r + 1'b1;
      end
    end else if (state_r == S_TICK) begin
      if (!scan_end) begin
        scan_r <= scan_r + 1'b1;
      end
      if (s3_v_r && s3_act_r && (!found_r || (s3_dl_r < best_r))) begin
        best_r  <= s3_dl_r;
        found_r <= 1'b1;
      end
    end

    s1_idx_r    <= scan_idx;
    s2_idx_r    <= s1_idx_r;
    s2_act_r    <= vld_r[s1_idx_r];
    s2_exp_r    <= (mem_q.deadline <= now_r);
    s2_per_r    <= mem_q.periodic;
    s2_sum_r    <= {1'b0, mem_q.deadline} + {22'd0, mem_q.period};
    s2_dl0_r    <= mem_q.deadline;
    s2_period_r <= mem_q.period;
    s3_act_r    <= s2_act_r && !(s2_exp_r && !s2_per_r);
    s3_dl_r     <= s2_exp_r ? s2_dl : s2_dl0_r;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_event_res  = out_ev_r;
  assign out_slot_index = out_idx_r;
  assign out_wait_us    = out_wait_r;
  assign out_last       = out_last_r;

  a_expiry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && ((out_event_res == optt_pkg::EV_EXPIRED) ||
                    (out_event_res == optt_pkg::EV_LATE))) |-> !out_last)
    else $error("Expiry result marked as last.");

  a_final_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && ((out_event_res == optt_pkg::EV_WAIT) ||
                    (out_event_res == optt_pkg::EV_NO_TIMERS)))
    |-> (!s2_v_r && !s3_v_r && (state_r == S_IDLE)))
    else $error("Tick summary emitted before the slot pipeline drained.");

  a_tick_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TICK) && mem_we) |-> (s2_v_r && s2_act_r && s2_exp_r && s2_per_r))
    else $error("Slot memory written during a tick without a periodic expiry.");

endmodule
